### hw/rtl/fwht_pkg.sv
// Shared types and codes for the Walsh-Hadamard transform block.
package fwht_pkg;

	typedef logic [1:0] st_t;

	localparam st_t ST_PUSH   = 2'd0;
	localparam st_t ST_DATA   = 2'd1;
	localparam st_t ST_REJECT = 2'd2;
	localparam st_t ST_EMPTY  = 2'd3;

	localparam int CFG_BITS = 4;
	localparam logic [CFG_BITS-1:0] SIZE_RESET = 4'd11;
	localparam logic [2:0] ADDR_SIZE_LOG2 = 3'd0;

	localparam int QDEPTH = 4;
	localparam int QW     = 2;

	typedef struct packed {
		st_t  kind;
		logic last;
	} cmd_ctl_t;

endpackage

### hw/rtl/fwht_front.sv
// Front end: accepts beats, classifies them against row state, queues commands.
module fwht_front import fwht_pkg::*; #(
	parameter int AW = 11,
	parameter int LW = 4,
	parameter int SW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CFG_BITS-1:0]  size_log2,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic signed [SW-1:0] sample,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output cmd_ctl_t             cmd_ctl,
	output logic [AW-1:0]        cmd_addr,
	output logic [LW-1:0]        cmd_lg,
	output logic signed [SW-1:0] cmd_sample
);

	localparam int CW = AW + 1;

	logic [CW-1:0] loaded_q;
	logic [AW-1:0] rptr_q;
	logic          draining_q;
	logic [LW-1:0] row_lg_q;

	logic [LW-1:0] eff_lg;
	logic [LW-1:0] use_lg;
	logic [CW-1:0] n_row;
	logic [CW-1:0] n_drain;
	logic          push_last;
	logic          pull_last;
	cmd_ctl_t      new_ctl;
	logic [AW-1:0] new_addr;

	cmd_ctl_t             q_ctl  [QDEPTH];
	logic [AW-1:0]        q_addr [QDEPTH];
	logic [LW-1:0]        q_lg   [QDEPTH];
	logic signed [SW-1:0] q_smp  [QDEPTH];
	logic [QW-1:0]        wp_q;
	logic [QW-1:0]        rp_q;
	logic [QW:0]          cnt_q;
	logic                 accept;
	logic                 pop;

	always_comb begin
		if (size_log2 == '0) begin
			eff_lg = LW'(1);
		end else if (32'(size_log2) > AW) begin
			eff_lg = LW'(AW);
		end else begin
			eff_lg = LW'(size_log2);
		end
	end

	assign use_lg    = (loaded_q == '0) ? eff_lg : row_lg_q;
	assign n_row     = CW'(1) << use_lg;
	assign n_drain   = CW'(1) << row_lg_q;
	assign push_last = (loaded_q + CW'(1)) >= n_row;
	assign pull_last = (CW'(rptr_q) + CW'(1)) >= n_drain;

	always_comb begin
		new_ctl.kind = ST_PUSH;
		new_ctl.last = 1'b0;
		new_addr     = loaded_q[AW-1:0];
		if (!action) begin
			if (draining_q) begin
				new_ctl.kind = ST_REJECT;
			end else begin
				new_ctl.last = push_last;
			end
		end else begin
			if (draining_q) begin
				new_ctl.kind = ST_DATA;
				new_ctl.last = pull_last;
				new_addr     = rptr_q;
			end else begin
				new_ctl.kind = ST_EMPTY;
			end
		end
	end

	assign in_ready  = cnt_q != (QW+1)'(QDEPTH);
	assign accept    = in_valid && in_ready;
	assign cmd_valid = cnt_q != '0;
	assign pop       = cmd_valid && cmd_ready;

	assign cmd_ctl    = q_ctl[rp_q];
	assign cmd_addr   = q_addr[rp_q];
	assign cmd_lg     = q_lg[rp_q];
	assign cmd_sample = q_smp[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q   <= '0;
			rptr_q     <= '0;
			draining_q <= 1'b0;
			row_lg_q   <= '0;
		end else if (accept) begin
			if (!action && !draining_q) begin
				row_lg_q <= use_lg;
				if (push_last) begin
					loaded_q   <= '0;
					rptr_q     <= '0;
					draining_q <= 1'b1;
				end else begin
					loaded_q <= loaded_q + CW'(1);
				end
			end else if (action && draining_q) begin
				if (pull_last) begin
					rptr_q     <= '0;
					draining_q <= 1'b0;
				end else begin
					rptr_q <= rptr_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				wp_q <= wp_q + QW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QW'(1);
			end
			cnt_q <= cnt_q + (QW+1)'(accept) - (QW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_ctl[wp_q]  <= new_ctl;
			q_addr[wp_q] <= new_addr;
			q_lg[wp_q]   <= use_lg;
			q_smp[wp_q]  <= sample;
		end
	end

endmodule

### hw/rtl/fwht_back.sv
// Back end: row store, butterfly sequencer and result register.
module fwht_back import fwht_pkg::*; #(
	parameter int AW = 11,
	parameter int LW = 4,
	parameter int SW = 16,
	parameter int VW = 27
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  cmd_ctl_t             cmd_ctl,
	input  logic [AW-1:0]        cmd_addr,
	input  logic [LW-1:0]        cmd_lg,
	input  logic signed [SW-1:0] cmd_sample,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [VW-1:0] value,
	output logic                 last_of_row,
	output st_t                  status
);

	localparam int CW = AW + 1;
	localparam logic [1:0] B_CMD   = 2'd0;
	localparam logic [1:0] B_XFORM = 2'd1;
	localparam logic [1:0] B_WAIT  = 2'd2;

	logic [1:0] state_q;

	logic signed [VW-1:0] mem [2**AW];
	logic signed [VW-1:0] rdata_q;
	logic                 re;
	logic [AW-1:0]        raddr;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic signed [VW-1:0] wdata;

	logic                 out_valid_q;
	logic signed [VW-1:0] value_q;
	logic                 last_q;
	st_t                  status_q;
	logic                 out_free;
	logic                 cmd_pop;
	logic                 pend_s1;
	logic                 pend_last_s1;

	logic [LW-1:0]        xlg_q;
	logic [LW-1:0]        pass_q;
	logic [AW-1:0]        bf_q;
	logic                 ph_q;
	logic [AW-1:0]        mask;
	logic [AW-1:0]        a_addr;
	logic [AW-1:0]        b_addr;
	logic                 bf_last;
	logic                 pass_last;

	logic                 rtag_v_s1;
	logic                 rtag_b_s1;
	logic [AW-1:0]        rtag_addr_s1;
	logic signed [VW-1:0] a_val_q;
	logic [AW-1:0]        a_addr_q;
	logic                 wr2_v_s2;
	logic [AW-1:0]        wr2_addr_s2;
	logic signed [VW-1:0] diff_s2;

	assign out_free  = !out_valid_q || out_ready;
	assign cmd_ready = (state_q == B_CMD) && out_free && !pend_s1;
	assign cmd_pop   = cmd_valid && cmd_ready;

	// Pair index with a zero bit inserted at the pass position.
	assign mask      = (AW'(1) << pass_q) - AW'(1);
	assign a_addr    = ((bf_q & ~mask) << 1) | (bf_q & mask);
	assign b_addr    = a_addr | (AW'(1) << pass_q);
	assign bf_last   = ((CW'(bf_q) + CW'(1)) << 1) == (CW'(1) << xlg_q);
	assign pass_last = LW'(pass_q + LW'(1)) == xlg_q;

	always_comb begin
		re    = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		if (cmd_pop && cmd_ctl.kind == ST_PUSH) begin
			we    = 1'b1;
			waddr = cmd_addr;
			wdata = VW'(cmd_sample);
		end
		if (cmd_pop && cmd_ctl.kind == ST_DATA) begin
			re    = 1'b1;
			raddr = cmd_addr;
		end
		if (state_q == B_XFORM) begin
			re    = 1'b1;
			raddr = ph_q ? b_addr : a_addr;
		end
		// sum and difference write-backs take turns on the write port
		if (rtag_v_s1 && rtag_b_s1) begin
			we    = 1'b1;
			waddr = a_addr_q;
			wdata = a_val_q + rdata_q;
		end else if (wr2_v_s2) begin
			we    = 1'b1;
			waddr = wr2_addr_s2;
			wdata = diff_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CMD;
			xlg_q     <= '0;
			pass_q    <= '0;
			bf_q      <= '0;
			ph_q      <= 1'b0;
			rtag_v_s1 <= 1'b0;
			wr2_v_s2  <= 1'b0;
		end else begin
			rtag_v_s1 <= state_q == B_XFORM;
			wr2_v_s2  <= rtag_v_s1 && rtag_b_s1;
			unique case (state_q)
				B_CMD: begin
					if (cmd_pop && cmd_ctl.kind == ST_PUSH && cmd_ctl.last) begin
						state_q <= B_XFORM;
						xlg_q   <= cmd_lg;
						pass_q  <= '0;
						bf_q    <= '0;
						ph_q    <= 1'b0;
					end
				end
				B_XFORM: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (bf_last) begin
							bf_q    <= '0;
							state_q <= B_WAIT;
						end else begin
							bf_q <= bf_q + AW'(1);
						end
					end
				end
				B_WAIT: begin
					// hold until the pass has written back
					if (!rtag_v_s1 && !wr2_v_s2) begin
						if (pass_last) begin
							state_q <= B_CMD;
						end else begin
							pass_q  <= pass_q + LW'(1);
							state_q <= B_XFORM;
						end
					end
				end
				default: begin
					state_q <= B_CMD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rtag_b_s1    <= ph_q;
		rtag_addr_s1 <= raddr;
		if (rtag_v_s1 && !rtag_b_s1) begin
			a_val_q  <= rdata_q;
			a_addr_q <= rtag_addr_s1;
		end
		diff_s2     <= a_val_q - rdata_q;
		wr2_addr_s2 <= rtag_addr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_s1      <= 1'b0;
			pend_last_s1 <= 1'b0;
		end else begin
			pend_s1      <= cmd_pop && cmd_ctl.kind == ST_DATA;
			pend_last_s1 <= cmd_ctl.last;
			if (cmd_pop && cmd_ctl.kind != ST_DATA) begin
				out_valid_q <= 1'b1;
			end else if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd_ctl.kind != ST_DATA) begin
			value_q  <= '0;
			last_q   <= 1'b0;
			status_q <= cmd_ctl.kind;
		end else if (pend_s1) begin
			value_q  <= rdata_q;
			last_q   <= pend_last_s1;
			status_q <= ST_DATA;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign last_of_row = last_q;
	assign status      = status_q;

	a_non_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_DATA |-> value_q == '0 && !last_q)
		else $error("non-data beat carries payload");

	a_pull_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !out_valid_q)
		else $error("pull data lands on an occupied result register");

	a_no_pop_in_xform: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != B_CMD |-> !cmd_pop)
		else $error("command taken during transform");

	a_diff_follows_b: assert property (@(posedge clk) disable iff (!arst_n)
		wr2_v_s2 |-> $past(rtag_v_s1 && rtag_b_s1))
		else $error("difference write without a paired read");

endmodule

### hw/rtl/fast_walsh_hadamard_transform.sv
// Top level of the unnormalized fast Walsh-Hadamard transform block.
// Push beats load one sample each into a row of n = 2^size_log2 points (size_log2 clamped
// to 1..log2(MAX_POINTS)); the push that completes a row starts log2(n) in-place butterfly
// passes over the row store, and pull beats then read the coefficients in index order. A
// front end classifies every beat and feeds a four-entry command queue, so pushes, rejects
// and empty pulls flow at one beat per cycle while the queue has room. The back end retires
// a push or a status beat straight into the result register and a pull through a
// registered read of the row store. The transform reads the two points of each butterfly in
// turn, limited by the store's one read and one write port, and at the end of each pass
// waits while the last write-back lands; queued beats wait during the transform. Results
// leave through a registered output.
module fast_walsh_hadamard_transform import fwht_pkg::*; #(
	parameter int MAX_POINTS  = 2048,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           psel,
	input  logic                                           penable,
	input  logic                                           pwrite,
	input  logic [2:0]                                     paddr,
	input  logic [31:0]                                    pwdata,
	output logic [31:0]                                    prdata,
	output logic                                           pready,
	input  logic                                           in_valid,
	output logic                                           in_ready,
	input  logic                                           action,
	input  logic signed [SAMPLE_BITS-1:0]                  sample,
	output logic                                           out_valid,
	input  logic                                           out_ready,
	output logic signed [SAMPLE_BITS+$clog2(MAX_POINTS)-1:0] value,
	output logic                                           last_of_row,
	output logic [1:0]                                     status
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int LW = $clog2(AW + 1);
	localparam int VW = SAMPLE_BITS + AW;

	logic [CFG_BITS-1:0]          size_q;
	logic                         sel_size;
	logic                         cmd_valid;
	logic                         cmd_ready;
	cmd_ctl_t                     cmd_ctl;
	logic [AW-1:0]                cmd_addr;
	logic [LW-1:0]                cmd_lg;
	logic signed [SAMPLE_BITS-1:0] cmd_sample;
	st_t                          status_w;

	assign pready   = 1'b1;
	assign sel_size = paddr[2:2] == ADDR_SIZE_LOG2[2:2];
	assign prdata   = sel_size ? 32'(size_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && pready && sel_size) begin
			size_q <= pwdata[CFG_BITS-1:0];
		end
	end

	fwht_front #(
		.AW(AW),
		.LW(LW),
		.SW(SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.size_log2 (size_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.sample    (sample),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_ctl   (cmd_ctl),
		.cmd_addr  (cmd_addr),
		.cmd_lg    (cmd_lg),
		.cmd_sample(cmd_sample)
	);

	fwht_back #(
		.AW(AW),
		.LW(LW),
		.SW(SAMPLE_BITS),
		.VW(VW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd_ctl    (cmd_ctl),
		.cmd_addr   (cmd_addr),
		.cmd_lg     (cmd_lg),
		.cmd_sample (cmd_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.last_of_row(last_of_row),
		.status     (status_w)
	);

	assign status = status_w;

endmodule

### bench/tb_fast_walsh_hadamard_transform.sv
// Self-checking testbench for the fast Walsh-Hadamard transform block.
`timescale 1ns / 1ps

module tb_fast_walsh_hadamard_transform;
	import fwht_pkg::*;

	localparam int MAXP = 2048;
	localparam int SBITS = 16;
	localparam int VBITS = 27;
	localparam int LIMIT = 3000000;

	typedef struct packed {
		logic signed [VBITS-1:0] value;
		logic                    last;
		st_t                     kind;
	} coef_t;

	typedef struct {
		logic                    act;
		logic signed [SBITS-1:0] smp;
		logic                    known;
		coef_t                   res;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready, action = 1'b0;
	logic signed [SBITS-1:0] sample = '0;
	logic out_valid, out_ready = 1'b0, last_of_row;
	logic signed [VBITS-1:0] value;
	logic [1:0] status;

	fast_walsh_hadamard_transform u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic signed [VBITS-1:0] row_mem[MAXP];
	int unsigned fill_cnt, rd_ptr, row_lg, size_reg;
	bit draining;

	coef_t expected_q[$];
	int errors = 0, n_checked = 0, n_rows = 0;
	int cycles = 0;
	bit hold_off = 1'b0, calm = 1'b0;

	function automatic coef_t mk(logic signed [VBITS-1:0] v, logic l, st_t k);
		coef_t c;
		c.value = v;
		c.last = l;
		c.kind = k;
		return c;
	endfunction

	function automatic coef_t fwht_predict(logic act, logic signed [SBITS-1:0] smp);
		int unsigned n, span, blk, j;
		logic signed [VBITS-1:0] a, b;
		coef_t c;
		if (!act) begin
			if (draining)
				return mk('0, 1'b0, ST_REJECT);
			if (fill_cnt == 0) begin
				row_lg = size_reg;
				if (row_lg < 1)
					row_lg = 1;
				if (row_lg > 11)
					row_lg = 11;
			end
			n = 1 << row_lg;
			row_mem[fill_cnt] = VBITS'(smp);
			fill_cnt++;
			if (fill_cnt >= n) begin
				for (span = 1; span < n; span <<= 1)
					for (blk = 0; blk < n; blk += 2 * span)
						for (j = blk; j < blk + span; j++) begin
							a = row_mem[j];
							b = row_mem[j + span];
							row_mem[j] = a + b;
							row_mem[j + span] = a - b;
						end
				fill_cnt = 0;
				rd_ptr = 0;
				draining = 1'b1;
			end
			return mk('0, 1'b0, ST_PUSH);
		end
		if (!draining)
			return mk('0, 1'b0, ST_EMPTY);
		n = 1 << row_lg;
		c = mk(row_mem[rd_ptr], rd_ptr + 1 >= n, ST_DATA);
		if (c.last) begin
			draining = 1'b0;
			rd_ptr = 0;
			n_rows++;
		end else begin
			rd_ptr++;
		end
		return c;
	endfunction

	task automatic write_size(int unsigned v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_SIZE_LOG2;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		size_reg = v & 15;
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Offer one beat, hold until accepted; the result goes on the queue.
	task automatic send_beat(logic act, logic signed [SBITS-1:0] smp, bit known, coef_t res);
		coef_t p;
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		sample <= smp;
		p = fwht_predict(act, smp);
		if (known && p !== res)
			$display("directed row disagrees with predictor: %h vs %h", res, p);
		expected_q.push_back(known ? res : p);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_row(int unsigned lg, int mode);
		int unsigned k;
		logic signed [SBITS-1:0] s;
		for (k = 0; k < (1 << lg); k++) begin
			case (mode)
				0: s = 16'sh7fff;
				1: s = 16'sh8000;
				default: s = SBITS'($urandom);
			endcase
			send_beat(1'b0, s, 1'b0, '0);
		end
		for (k = 0; k < (1 << lg); k++)
			send_beat(1'b1, SBITS'($urandom), 1'b0, '0);
	endtask

	// receiver with random stalls and a long hold-off on request
	always @(posedge clk) begin
		int stall;
		cycles <= cycles + 1;
		if (hold_off)
			out_ready <= 1'b0;
		else if (stall > 0) begin
			stall--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall = $urandom_range(1, 12);
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		coef_t want, got;
		if (arst_n && out_valid && out_ready) begin
			got = mk(value, last_of_row, status);
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: value=%0d last=%b status=%0d",
						value, last_of_row, status);
			end else begin
				want = expected_q.pop_front();
				n_checked++;
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp value=%0d last=%b status=%0d, got value=%0d last=%b status=%0d",
							want.value, want.last, want.kind, got.value, got.last, got.kind);
				end
			end
		end
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	vec_t dir_tab[] = '{
		'{1'b1, 16'sh0000, 1'b1, '{'0, 1'b0, ST_EMPTY}},
		'{1'b0, 16'sh7fff, 1'b1, '{'0, 1'b0, ST_PUSH}},
		'{1'b0, 16'sh8000, 1'b1, '{'0, 1'b0, ST_PUSH}},
		'{1'b0, 16'sh1234, 1'b1, '{'0, 1'b0, ST_REJECT}},
		'{1'b1, 16'shffff, 1'b1, '{27'sd32767 - 27'sd32768, 1'b0, ST_DATA}},
		'{1'b1, 16'sh0000, 1'b1, '{27'sd65535, 1'b1, ST_DATA}},
		'{1'b1, 16'sh0000, 1'b1, '{'0, 1'b0, ST_EMPTY}},
		'{1'b0, 16'shffff, 1'b1, '{'0, 1'b0, ST_PUSH}},
		'{1'b1, 16'sh0000, 1'b1, '{'0, 1'b0, ST_EMPTY}},
		'{1'b0, 16'sh0001, 1'b1, '{'0, 1'b0, ST_PUSH}},
		'{1'b1, 16'sh0000, 1'b0, '{'0, 1'b0, ST_DATA}},
		'{1'b1, 16'sh0000, 1'b0, '{'0, 1'b0, ST_DATA}}
	};

	initial begin
		int i, lg, k;
		fill_cnt = 0;
		rd_ptr = 0;
		row_lg = 0;
		draining = 1'b0;
		size_reg = 11;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed rows at two points; the size-0 write maps to one
		write_size(0);
		foreach (dir_tab[i])
			send_beat(dir_tab[i].act, dir_tab[i].smp, dir_tab[i].known, dir_tab[i].res);
		drain_and_settle();

		// extreme rows, once all-max, once all-min
		write_size(7);
		send_row(7, 0);
		drain_and_settle();
		write_size(7);
		send_row(7, 1);
		drain_and_settle();

		// long output hold-off while beats keep coming
		write_size(3);
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			send_row(3, 2);
		join
		drain_and_settle();

		// random part: mostly well-formed rows, some noise and mid-row size changes
		for (i = 0; i < 900; ) begin
			lg = $urandom_range(1, 4);
			if (i > 750)
				calm = 1'b1;
			write_size($urandom_range(0, 9) == 0 ? 0 : lg);
			for (k = 0; k < (1 << lg) * 2 + 4 && i < 900; k++, i++) begin
				if ($urandom_range(0, 5) == 0)
					send_beat(1'($urandom), SBITS'($urandom), 1'b0, '0);
				else
					send_beat(k >= (1 << lg), SBITS'($urandom), 1'b0, '0);
			end
			drain_and_settle();
		end
		drain_and_settle();

		$display("checked %0d result beats over %0d completed rows, sizes 2..128",
			n_checked, n_rows);
		$display("with extreme rows, an output hold-off and random stalls on both sides");
		if (errors == 0 && expected_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
hw/rtl/fwht_pkg.sv
hw/rtl/fwht_front.sv
hw/rtl/fwht_back.sv
hw/rtl/fast_walsh_hadamard_transform.sv
bench/tb_fast_walsh_hadamard_transform.sv
